// ===== src/ctok_pkg.sv =====
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, codes and helper functions of the C source tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int LENGTH_BITS    = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int OUT_LEN_BITS   = 16;

  typedef logic [LENGTH_BITS-1:0] run_t;

  localparam run_t RUN_MAX = {LENGTH_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DETECT,
    MODE_SLASH,
    MODE_ERROR
  } mode_t;

  typedef enum logic [3:0] {
    KIND_MACRO  = 4'd0,
    KIND_STRING = 4'd1,
    KIND_CHAR   = 4'd2,
    KIND_IDENT  = 4'd3,
    KIND_DIGITS = 4'd4,
    KIND_BLANKS = 4'd5,
    KIND_LF     = 4'd6,
    KIND_CR     = 4'd7,
    KIND_SYMBOL = 4'd8,
    KIND_LINE   = 4'd9,
    KIND_BLOCK  = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    ST_TOKEN     = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_MACRO_ESC = 3'd2,
    ST_STRING    = 3'd3,
    ST_CHAR      = 3'd4,
    ST_COMMENT   = 3'd5
  } status_t;

  // byte classes as the scanner needs them
  typedef enum logic [3:0] {
    CLS_LF,
    CLS_CR,
    CLS_HASH,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_SLASH,
    CLS_STAR,
    CLS_BSLASH,
    CLS_SYMBOL,
    CLS_IDENT,
    CLS_BLANK,
    CLS_DIGIT,
    CLS_OTHER,
    CLS_END
  } class_t;

  typedef struct packed {
    logic   valid;
    class_t cls;
  } head_t;

  typedef struct packed {
    kind_t                   kind;
    logic [OUT_LEN_BITS-1:0] length;
    status_t                 status;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic class_t classify(input logic [7:0] b, input logic eoi);
    class_t c;
    c = CLS_OTHER;
    if (eoi) begin
      c = CLS_END;
    end else begin
      case (b)
        8'h0A: c = CLS_LF;
        8'h0D: c = CLS_CR;
        8'h23: c = CLS_HASH;
        8'h22: c = CLS_DQUOTE;
        8'h27: c = CLS_SQUOTE;
        8'h2F: c = CLS_SLASH;
        8'h2A: c = CLS_STAR;
        8'h5C: c = CLS_BSLASH;
        8'h20, 8'h09: c = CLS_BLANK;
        8'h5F: c = CLS_IDENT;
        // nul and : . ; , ( ) { } [ ] < > = - + | & ^ % ! ? ~
        8'h00, 8'h3A, 8'h2E, 8'h3B, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D,
        8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h3D, 8'h2D, 8'h2B, 8'h7C, 8'h26,
        8'h5E, 8'h25, 8'h21, 8'h3F, 8'h7E: c = CLS_SYMBOL;
        default: begin
          if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
            c = CLS_IDENT;
          end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CLS_DIGIT;
          end else begin
            c = CLS_OTHER;
          end
        end
      endcase
    end
    return c;
  endfunction

  function automatic logic [OUT_LEN_BITS-1:0] sat_len(input run_t v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'd65535) begin
      return {OUT_LEN_BITS{1'b1}};
    end
    return w[OUT_LEN_BITS-1:0];
  endfunction

endpackage

// ===== src/c_source_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// c_source_tokenizer_unit
// Cuts a C source byte stream into tokens with kind, length and status.
// ----------------------------------------------------------------------------
// Input channel: one source byte per item, or an end flag that flushes the
// pending token. Output channel: one result per item on the output side;
// a byte may give zero, one or two results, and last_of_run marks the final
// result of an input item.
// Throughput: one byte per cycle while the result queue has room for a pair
// of results. A byte that gives two results hands them out one after the
// other, so a long run of such bytes is bounded by the output port.
// A byte waits in the four-entry byte queue and its results are registered
// in the result queue, which drives the output.
// The scanner only takes a byte when the result queue can hold two results.
// When the receiver stalls, results wait in the four-entry result queue and
// the byte queue fills behind it; in_stall rises when the byte queue is full.
// After an unknown byte or an unclosed construct at end of input the block
// gives one error result and then stays silent until reset.
// Reset (synchronous) empties both queues and returns the scanner to idle.
// ----------------------------------------------------------------------------
module c_source_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_length,
  output logic [2:0]  status,
  output logic        last_of_run
);
  import ctok_pkg::*;

  head_t head;
  push_t push;
  logic  pop;
  logic  room;

  ctok_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_byte  (source_byte),
    .end_of_input (end_of_input),
    .pop          (pop),
    .head         (head)
  );

  ctok_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .room (room),
    .pop  (pop),
    .push (push)
  );

  ctok_out_queue u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_length (token_length),
    .status       (status),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== src/ctok_front.sv =====
// ----------------------------------------------------------------------------
// ctok_front
// Accepts source bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ctok_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     source_byte,
  input  logic           end_of_input,
  input  logic           pop,
  output ctok_pkg::head_t head
);
  import ctok_pkg::*;

  class_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      push;
  logic                      do_pop;

  assign in_stall = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && head.valid;

  assign head.valid = (count != '0);
  assign head.cls   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= classify(source_byte, end_of_input);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(do_pop);
    end
  end

endmodule

// ===== src/ctok_back.sv =====
// ----------------------------------------------------------------------------
// ctok_back
// Token scanner: takes classified bytes and produces up to two results each.
// ----------------------------------------------------------------------------
module ctok_back (
  input  logic            clk,
  input  logic            rst,
  input  ctok_pkg::head_t head,
  input  logic            room,
  output logic            pop,
  output ctok_pkg::push_t push
);
  import ctok_pkg::*;

  mode_t  mode, mode_next;
  kind_t  kind, kind_next;
  logic   esc, esc_next;
  run_t   run, run_next;
  logic   prev_star, prev_star_next;

  logic                    a_v, b_v, do_idle, closing;
  kind_t                   a_kind, b_kind;
  logic [OUT_LEN_BITS-1:0] a_len, b_len;
  status_t                 a_st, b_st;
  run_t                    grown;
  class_t                  cls;

  assign pop = head.valid && room;
  assign cls = head.cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      kind      <= KIND_MACRO;
      esc       <= 1'b0;
      run       <= '0;
      prev_star <= 1'b0;
    end else if (pop) begin
      mode      <= mode_next;
      kind      <= kind_next;
      esc       <= esc_next;
      run       <= run_next;
      prev_star <= prev_star_next;
    end
  end

  always_comb begin
    mode_next      = mode;
    kind_next      = kind;
    esc_next       = esc;
    run_next       = run;
    prev_star_next = prev_star;
    a_v     = 1'b0;
    a_kind  = kind;
    a_len   = sat_len(run);
    a_st    = ST_TOKEN;
    b_v     = 1'b0;
    b_kind  = KIND_LF;
    b_len   = OUT_LEN_BITS'(1);
    b_st    = ST_TOKEN;
    do_idle = 1'b0;
    closing = 1'b0;
    grown   = (run == RUN_MAX) ? run : run + 1'b1;

    if (mode != MODE_ERROR) begin
      if (cls == CLS_END) begin
        mode_next = MODE_IDLE;
        case (mode)
          MODE_SLASH: begin
            a_v    = 1'b1;
            a_kind = KIND_SYMBOL;
            a_len  = OUT_LEN_BITS'(1);
          end
          MODE_DETECT: begin
            a_v = 1'b1;
            if (kind == KIND_MACRO && esc) begin
              a_st = ST_MACRO_ESC;
            end else if (kind == KIND_STRING) begin
              a_st = ST_STRING;
            end else if (kind == KIND_CHAR) begin
              a_st = ST_CHAR;
            end else if (kind == KIND_BLOCK) begin
              a_st = ST_COMMENT;
            end
            if (a_st != ST_TOKEN) begin
              mode_next = MODE_ERROR;
            end
          end
          default: ;
        endcase
      end else begin
        prev_star_next = (cls == CLS_STAR);
        case (mode)
          MODE_SLASH: begin
            if (cls == CLS_SLASH || cls == CLS_STAR) begin
              mode_next = MODE_DETECT;
              kind_next = (cls == CLS_SLASH) ? KIND_LINE : KIND_BLOCK;
              esc_next  = 1'b0;
              run_next  = run_t'(2);
            end else begin
              a_v       = 1'b1;
              a_kind    = KIND_SYMBOL;
              a_len     = OUT_LEN_BITS'(1);
              mode_next = MODE_IDLE;
              do_idle   = 1'b1;
            end
          end
          MODE_DETECT: begin
            case (kind)
              KIND_MACRO: begin
                if (cls == CLS_LF && !esc) begin
                  a_v       = 1'b1;
                  mode_next = MODE_IDLE;
                  do_idle   = 1'b1;
                end else begin
                  if (cls == CLS_LF) begin
                    esc_next = 1'b0;
                  end else if (cls == CLS_BSLASH) begin
                    esc_next = !esc;
                  end
                  run_next = grown;
                end
              end
              KIND_STRING, KIND_CHAR: begin
                run_next = grown;
                if (!esc && ((kind == KIND_STRING && cls == CLS_DQUOTE) ||
                             (kind == KIND_CHAR && cls == CLS_SQUOTE))) begin
                  a_v       = 1'b1;
                  a_len     = sat_len(grown);
                  mode_next = MODE_IDLE;
                end else if (cls == CLS_BSLASH) begin
                  esc_next = !esc;
                end else begin
                  esc_next = 1'b0;
                end
              end
              KIND_BLOCK: begin
                // closes on a slash right after a star, never on the opening pair
                closing  = prev_star && (cls == CLS_SLASH) && (run >= run_t'(3));
                run_next = grown;
                if (closing) begin
                  a_v       = 1'b1;
                  a_len     = sat_len(grown);
                  mode_next = MODE_IDLE;
                end
              end
              default: begin
                if ((kind == KIND_IDENT  && cls == CLS_IDENT) ||
                    (kind == KIND_BLANKS && cls == CLS_BLANK) ||
                    (kind == KIND_DIGITS && cls == CLS_DIGIT) ||
                    (kind != KIND_IDENT && kind != KIND_BLANKS &&
                     kind != KIND_DIGITS && cls != CLS_LF)) begin
                  run_next = grown;
                end else begin
                  a_v       = 1'b1;
                  mode_next = MODE_IDLE;
                  do_idle   = 1'b1;
                end
              end
            endcase
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        // the byte starts a new token
        if (do_idle) begin
          case (cls)
            CLS_LF: begin
              b_v    = 1'b1;
              b_kind = KIND_LF;
            end
            CLS_CR: begin
              b_v    = 1'b1;
              b_kind = KIND_CR;
            end
            CLS_SYMBOL, CLS_STAR: begin
              b_v    = 1'b1;
              b_kind = KIND_SYMBOL;
            end
            CLS_SLASH: begin
              mode_next = MODE_SLASH;
              run_next  = run_t'(1);
            end
            CLS_HASH, CLS_DQUOTE, CLS_SQUOTE, CLS_IDENT, CLS_BLANK, CLS_DIGIT: begin
              mode_next = MODE_DETECT;
              esc_next  = 1'b0;
              run_next  = run_t'(1);
              case (cls)
                CLS_HASH:   kind_next = KIND_MACRO;
                CLS_DQUOTE: kind_next = KIND_STRING;
                CLS_SQUOTE: kind_next = KIND_CHAR;
                CLS_IDENT:  kind_next = KIND_IDENT;
                CLS_BLANK:  kind_next = KIND_BLANKS;
                default:    kind_next = KIND_DIGITS;
              endcase
            end
            default: begin
              b_v       = 1'b1;
              b_kind    = KIND_MACRO;
              b_len     = '0;
              b_st      = ST_UNKNOWN;
              mode_next = MODE_ERROR;
            end
          endcase
        end
      end
    end
  end

  // results in order: flushed token first, then the one the byte makes
  always_comb begin
    push.count         = {a_v && b_v, a_v ^ b_v};
    push.second.kind   = b_kind;
    push.second.length = b_len;
    push.second.status = b_st;
    push.second.last   = 1'b1;
    if (a_v) begin
      push.first.kind   = a_kind;
      push.first.length = a_len;
      push.first.status = a_st;
      push.first.last   = !b_v;
    end else begin
      push.first = push.second;
    end
    if (!pop) begin
      push.count = 2'd0;
    end
  end

endmodule

// ===== src/ctok_out_queue.sv =====
// ----------------------------------------------------------------------------
// ctok_out_queue
// Result queue: takes up to two results a cycle, hands out one a cycle when not stalled.
// ----------------------------------------------------------------------------
module ctok_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  ctok_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      token_kind,
  output logic [15:0]     token_length,
  output logic [2:0]      status,
  output logic            last_of_run
);
  import ctok_pkg::*;

  result_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      pop;
  result_t                   head;

  // room for a full pair of results
  assign room      = (count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  assign head         = mem[rd_ptr];
  assign token_kind   = head.kind;
  assign token_length = head.length;
  assign status       = head.status;
  assign last_of_run  = head.last;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_PTR_BITS+1)'(push.count) - (QUEUE_PTR_BITS+1)'(pop);
    end
  end

endmodule

// ===== src/ctok_checker.sv =====
// ----------------------------------------------------------------------------
// ctok_checker
// Port-level checks of the tokenizer's result channel.
// ----------------------------------------------------------------------------
module ctok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  token_kind,
  input logic [15:0] token_length,
  input logic [2:0]  status,
  input logic        last_of_run
);
  import ctok_pkg::*;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
      $stable(token_length) && $stable(status) && $stable(last_of_run))
    else $error("stalled result changed");

  // both results of a byte are queued together, so the second follows at once
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("second result of a byte missing");

  // an error result always closes its run
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TOKEN |-> last_of_run)
    else $error("error result not last of run");

  // unknown byte reports an empty macro kind
  a_unknown_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNKNOWN |-> token_kind == KIND_MACRO && token_length == '0)
    else $error("unknown byte result malformed");

endmodule

bind c_source_tokenizer_unit ctok_checker u_ctok_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .token_kind   (token_kind),
  .token_length (token_length),
  .status       (status),
  .last_of_run  (last_of_run)
);
